/* sv/phcp_pkg.sv */
// Shared types, constants and helper functions for the prefixed hex command parser.
`default_nettype none

package phcp_pkg;

    // Status codes carried on the result channel
    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_OK   = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    // One result item
    typedef struct packed {
        logic [7:0] data_byte;
        logic [6:0] byte_count;
        status_t    status;
        logic       last;
    } res_t;

    // Byte buffer size behind the parser; caps the configured limit
    localparam int BUFFER_BYTES = 64;
    localparam logic [6:0] LIMIT_CAP =
        (BUFFER_BYTES >= 127) ? 7'd127 : 7'(BUFFER_BYTES);

    localparam logic [6:0] MAX_BYTES_RESET = 7'd64;

    localparam int PREFIX_LEN = 6;
    localparam logic [2:0] PREFIX_LAST = 3'(PREFIX_LEN - 1);

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_UC_A = 8'h41;
    localparam logic [7:0] CH_UC_F = 8'h46;
    localparam logic [7:0] CH_LC_A = 8'h61;
    localparam logic [7:0] CH_LC_F = 8'h66;
    localparam logic [7:0] ALPHA_BASE = 8'd10;

    // Expected prefix character "@send " by position
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        begin
            unique case (pos)
                3'd0:    c = 8'h40;  // '@'
                3'd1:    c = 8'h73;  // 's'
                3'd2:    c = 8'h65;  // 'e'
                3'd3:    c = 8'h6E;  // 'n'
                3'd4:    c = 8'h64;  // 'd'
                3'd5:    c = 8'h20;  // ' '
                default: c = 8'hFF;
            endcase
            return c;
        end
    endfunction

    // {bad, value}: bad set when c is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        begin
            if (c >= CH_LC_A && c <= CH_LC_F)
                v = {1'b0, 4'(c - CH_LC_A + ALPHA_BASE)};
            else if (c >= CH_UC_A && c <= CH_UC_F)
                v = {1'b0, 4'(c - CH_UC_A + ALPHA_BASE)};
            else if (c >= CH_0 && c <= CH_9)
                v = {1'b0, 4'(c - CH_0)};
            else
                v = 5'b1_0000;
            return v;
        end
    endfunction

endpackage

`default_nettype wire

/* sv/prefixed_hex_command_parser_core.sv */
// Top level of the prefixed hex command parser: input, limit, parser and result registers.
//
//  channel   signals                         direction  transfer when
//  -------   ------------------------------  ---------  --------------------------
//  input     in_valid, in_stall, char_in     in         in_valid && !in_stall
//  output    out_valid, out_stall, data_byte,
//            byte_count, status, last        out        out_valid && !out_stall
//  config    cfg_wr_en, cfg_wr_data          in         cfg_wr_en
//
//  One character per cycle sustained while the output is not stalled: a character is
//  decoded while it sits in the input register and lands in the result register
//  once that register has room. Characters that give no result retire from the
//  input register without touching the output.
//  Reset clears the parser to the start of a command, empties both registers and
//  sets the byte limit to 64. No clearing pass is needed.
//  While the output is stalled with a result held, the input register holds one
//  more character and in_stall rises only once that register is also occupied.
`default_nettype none

module prefixed_hex_command_parser_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_in,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      data_byte,
    output logic [6:0]      byte_count,
    output logic [1:0]      status,
    output logic            last,
    input  wire logic       cfg_wr_en,
    input  wire logic [6:0] cfg_wr_data
);
    import phcp_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic [6:0] max_bytes_reg;
    logic [6:0] limit;

    logic       out_free;
    logic       s1_move;
    logic       in_take;
    logic       res_valid;
    res_t       res;
    res_t       out_res;

    // effective limit is min(max_bytes, buffer size)
    assign limit = (max_bytes_reg > LIMIT_CAP) ? LIMIT_CAP : max_bytes_reg;

    // held character retires when the result register has room
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_char_reg <= char_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_bytes_reg <= MAX_BYTES_RESET;
        else if (cfg_wr_en)
            max_bytes_reg <= cfg_wr_data;
    end

    phcp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_move),
        .char_in   (s1_char_reg),
        .limit     (limit),
        .res_valid (res_valid),
        .res       (res)
    );

    phcp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_move),
        .res_valid (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign data_byte  = out_res.data_byte;
    assign byte_count = out_res.byte_count;
    assign status     = out_res.status;
    assign last       = out_res.last;

    a_stall_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid))
        else $error("input stalled with nothing held");

    a_held_char_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_char_reg)))
        else $error("held character lost before decode");

    a_limit_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (limit <= LIMIT_CAP) && (limit <= max_bytes_reg))
        else $error("effective limit above cap");

endmodule

`default_nettype wire

/* sv/phcp_parser.sv */
// Parser state and combinational character decode.
`default_nettype none

module phcp_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    char_in,
    input  wire logic [6:0]    limit,
    output logic               res_valid,
    output phcp_pkg::res_t     res
);
    import phcp_pkg::*;

    typedef enum logic [3:0] {
        PH_PREFIX = 4'b0001,
        PH_HIGH   = 4'b0010,
        PH_LOW    = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] pos_reg, pos_next;
    logic [3:0] nibble_reg, nibble_next;
    logic [6:0] bytes_reg, bytes_next;

    logic [4:0] hv;
    logic       is_nul;
    logic [6:0] bytes_inc;
    logic       do_rearm;

    assign hv        = hex_value(char_in);
    assign is_nul    = (char_in == CH_NUL);
    assign bytes_inc = bytes_reg + 7'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        nibble_next = nibble_reg;
        bytes_next  = bytes_reg;
        do_rearm    = 1'b0;
        res_valid   = 1'b0;
        res.data_byte  = 8'd0;
        res.byte_count = bytes_reg;
        res.status     = ST_DATA;
        res.last       = 1'b0;

        if (step)
        begin
            unique case (phase_reg)
                PH_PREFIX:
                begin
                    if (char_in != prefix_char(pos_reg))
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_ERR;
                        res.last   = 1'b1;
                        phase_next = PH_DONE;
                        do_rearm   = is_nul;
                    end
                    else if (pos_reg == PREFIX_LAST)
                    begin
                        phase_next = PH_HIGH;
                    end
                    else
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                end
                PH_HIGH:
                begin
                    if (bytes_reg >= limit || is_nul)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_OK;
                        res.last   = 1'b1;
                        phase_next = PH_DONE;
                        do_rearm   = is_nul;
                    end
                    else if (hv[4])
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_ERR;
                        res.last   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        nibble_next = hv[3:0];
                        phase_next  = PH_LOW;
                    end
                end
                PH_LOW:
                begin
                    res_valid = 1'b1;
                    res.last  = 1'b1;
                    if (hv[4])
                    begin
                        res.status = ST_ERR;
                        phase_next = PH_DONE;
                        do_rearm   = is_nul;
                    end
                    else
                    begin
                        bytes_next     = bytes_inc;
                        res.data_byte  = {nibble_reg, hv[3:0]};
                        res.byte_count = bytes_inc;
                        res.last       = (bytes_inc >= limit);
                        phase_next     = (bytes_inc >= limit) ? PH_DONE : PH_HIGH;
                    end
                end
                PH_DONE:
                begin
                    do_rearm = is_nul;
                end
            endcase

            if (do_rearm)
            begin
                phase_next = PH_PREFIX;
                pos_next   = 3'd0;
                bytes_next = 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            pos_reg   <= 3'd0;
            bytes_reg <= 7'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            bytes_reg <= bytes_next;
        end
    end

    // held digit: payload only
    always_ff @(posedge clk)
    begin
        nibble_reg <= nibble_next;
    end

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("parser phase not one-hot");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PREFIX) |-> (pos_reg <= PREFIX_LAST))
        else $error("prefix position out of range");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status != ST_DATA) |-> res.last)
        else $error("end result without last");

    a_rearm_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_DONE && is_nul) |=>
            (phase_reg == PH_PREFIX && pos_reg == 3'd0 && bytes_reg == 7'd0))
        else $error("terminator did not rearm parser");

endmodule

`default_nettype wire

/* sv/phcp_out_reg.sv */
// Result register on the output channel.
`default_nettype none

module phcp_out_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire logic          res_valid,
    input  wire phcp_pkg::res_t res,
    input  wire logic          out_stall,
    output logic               out_free,
    output logic               out_valid,
    output phcp_pkg::res_t     out_res
);
    import phcp_pkg::*;

    logic valid_reg;
    res_t res_reg;

    // room when empty or when the held result transfers this cycle
    assign out_free  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (out_free)
            valid_reg <= load && res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && load && res_valid)
            res_reg <= res;
    end

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.status == ST_DATA) |-> (res_reg.byte_count != 7'd0))
        else $error("data byte with zero count");

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !out_free) |-> 1'b0)
        else $error("load while result register blocked");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.status != ST_DATA) |-> (res_reg.data_byte == 8'd0))
        else $error("end result carries data");

endmodule

`default_nettype wire
